// ----- src/knn_pkg.sv -----
// Package for the k-nearest-neighbor classifier: sizes, command and status
// codes, item types and the shared top-k cell interface. No dependencies.
package knn_pkg;

  localparam int MaxTraining = 256;
  localparam int MaxFeatures = 64;
  localparam int MaxK        = 16;
  localparam int NumClasses  = 16;

  localparam int SlotW = $clog2(MaxTraining);
  localparam int FeatW = $clog2(MaxFeatures);
  localparam int AddrW = SlotW + FeatW;
  localparam int DistW = 22;
  localparam int KW    = $clog2(MaxK);

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  localparam logic REG_K   = 1'b0;
  localparam logic REG_LEN = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] feature_value;
    logic [3:0] class_label;
    logic       last_feature;
  } in_item_t;

  typedef struct packed {
    logic [3:0] predicted_label;
    logic [1:0] status;
  } out_item_t;

  // candidate traveling down the cell chain
  typedef struct packed {
    logic             vld;
    logic [DistW-1:0] sq_dist;
    logic [SlotW-1:0] idx;
    logic [3:0]       label;
  } cand_t;

  typedef struct packed {
    logic clear;
    logic active;
  } cell_ctl_t;

endpackage

// ----- src/knn_cell.sv -----
// One slot of the sorted top-k chain. Keeps the best candidate seen so far
// and hands the displaced one to its neighbor. Depends on knn_pkg.
module knn_cell (
  input  logic              clk,
  input  logic              rst,
  input  knn_pkg::cell_ctl_t ctl,
  input  knn_pkg::cand_t    cin,
  output knn_pkg::cand_t    cout,
  output knn_pkg::cand_t    held
);

  knn_pkg::cand_t slot;
  logic           wins;

  assign held = slot;

  // equal distances go to the lower store index
  assign wins = cin.vld && (!slot.vld || cin.sq_dist < slot.sq_dist
                || (cin.sq_dist == slot.sq_dist && cin.idx < slot.idx));

  always_ff @(posedge clk) begin
    if (rst) begin
      slot     <= '0;
      cout.vld <= 1'b0;
    end else if (ctl.clear) begin
      slot.vld <= 1'b0;
      cout.vld <= 1'b0;
    end else if (ctl.active) begin
      if (wins) begin
        slot <= cin;
        cout <= slot;
      end else begin
        cout <= cin;
      end
    end else begin
      cout.vld <= 1'b0;
    end
  end

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> !slot.vld) else $error("cell not cleared");
  a_idle_no_out: assert property (@(posedge clk) disable iff (rst)
    (!ctl.active && !ctl.clear) |=> !cout.vld) else $error("output while idle");
  a_slot_kept: assert property (@(posedge clk) disable iff (rst)
    (slot.vld && !ctl.clear) |=> slot.vld) else $error("held candidate lost");

endmodule

// ----- src/knn_classifier_unit.sv -----
// Top level of the k-nearest-neighbor classifier: training store, distance
// walk, top-k cell chain and majority vote. Depends on knn_pkg, knn_cell.
//
//  channel | dir | handshake               | payload
//  in      | in  | in_valid / in_ready     | knn_pkg::in_item_t
//  out     | out | out_valid / out_ready   | knn_pkg::out_item_t
//  cfg     | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// After a query's final feature the result follows a walk at one feature per cycle
// through the single memory read port, then pipeline and chain drain, the vote over
// the held candidates and the class scan.
// Reset is synchronous; stores are not cleared (only counts).
// Input stalls while a query runs or its result waits on out_ready; cfg waits on a query.
module knn_classifier_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  knn_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output knn_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_VOTE  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;

  localparam int CntW = knn_pkg::SlotW + 1;

  logic [2:0] state;
  logic [4:0] k_reg;
  logic [6:0] len_reg;
  logic [CntW-1:0] stored;
  logic [6:0] pos;

  logic [7:0] tmem [knn_pkg::MaxTraining*knn_pkg::MaxFeatures];
  logic [3:0] lmem [knn_pkg::MaxTraining];
  logic [7:0] qmem [knn_pkg::MaxFeatures];

  logic [6:0] len_eff;
  logic [4:0] k_eff;
  logic       accept;

  always_comb begin
    len_eff = (len_reg == 7'd0) ? 7'd1 :
              (len_reg > 7'(knn_pkg::MaxFeatures)) ? 7'(knn_pkg::MaxFeatures) : len_reg;
    k_eff = (k_reg == 5'd0) ? 5'd1 :
            (k_reg > 5'(knn_pkg::MaxK)) ? 5'(knn_pkg::MaxK) : k_reg;
    if ({4'd0, k_eff} > stored) k_eff = stored[4:0];
  end

  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign cfg_ready = (state == S_IDLE);
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_reg   <= 5'd1;
      len_reg <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == knn_pkg::REG_K) k_reg <= cfg_data[4:0];
      else len_reg <= cfg_data;
    end
  end

  // walk state
  logic [knn_pkg::SlotW-1:0] w_slot;
  logic [knn_pkg::FeatW-1:0] w_feat;
  logic [7:0]  rd_t, rd_q;
  logic [3:0]  rd_l;
  logic        p1_vld, p1_end;
  logic [7:0]  diff;
  logic [15:0] sq;
  logic        p2_vld, p2_end;
  logic        p3_vld, p3_end;
  logic [knn_pkg::DistW-1:0] acc;
  logic [knn_pkg::SlotW-1:0] cand_idx;
  logic [5:0]  drain_cnt;
  logic [knn_pkg::NumClasses-1:0][4:0] votes;
  logic [4:0]  vi;
  logic [4:0]  maxc;
  logic [3:0]  best;
  logic [3:0]  vote_lbl;

  knn_pkg::cand_t    chain [knn_pkg::MaxK+1];
  knn_pkg::cand_t    held  [knn_pkg::MaxK];
  knn_pkg::cell_ctl_t cctl;

  logic w_last_feat, w_last_slot;
  assign w_last_feat = ({1'b0, w_feat} == 7'(len_eff - 7'd1));
  assign w_last_slot = ({1'b0, w_slot} == CntW'(stored - 1'b1));

  always_ff @(posedge clk) begin
    rd_t <= tmem[{w_slot, w_feat}];
    rd_q <= qmem[w_feat];
    rd_l <= lmem[w_slot];
    if (accept && in_item.cmd == knn_pkg::CMD_LOAD && pos < len_eff
        && stored < CntW'(knn_pkg::MaxTraining))
      tmem[{stored[knn_pkg::SlotW-1:0], pos[knn_pkg::FeatW-1:0]}] <= in_item.feature_value;
    if (accept && in_item.cmd == knn_pkg::CMD_QUERY && pos < len_eff)
      qmem[pos[knn_pkg::FeatW-1:0]] <= in_item.feature_value;
    if (accept && in_item.cmd == knn_pkg::CMD_LOAD && in_item.last_feature
        && pos + 7'd1 == len_eff && stored < CntW'(knn_pkg::MaxTraining))
      lmem[stored[knn_pkg::SlotW-1:0]] <= in_item.class_label;
  end

  logic [6:0] cnt;
  assign cnt = (pos < 7'd127) ? pos + 7'd1 : 7'd127;

  assign cctl.clear  = accept;
  assign cctl.active = (state == S_WALK) || (state == S_DRAIN);

  always_comb begin
    chain[0].vld     = p3_vld && p3_end;
    chain[0].sq_dist = acc + knn_pkg::DistW'(sq);
    chain[0].idx     = cand_idx;
    chain[0].label   = vote_lbl;
  end

  for (genvar g = 0; g < knn_pkg::MaxK; g++) begin : g_cell
    knn_cell u_cell (
      .clk (clk), .rst (rst), .ctl (cctl),
      .cin (chain[g]), .cout (chain[g+1]), .held (held[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stored    <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
      p1_vld    <= 1'b0;
      p2_vld    <= 1'b0;
      p3_vld    <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      p1_vld <= (state == S_WALK);
      p2_vld <= p1_vld;
      p2_end <= p1_end;
      p3_vld <= p2_vld;
      p3_end <= p2_end;
      diff   <= (rd_q > rd_t) ? rd_q - rd_t : rd_t - rd_q;
      sq     <= diff * diff;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority if (in_item.cmd == knn_pkg::CMD_CLEAR) begin
              stored <= '0;
              pos    <= '0;
            end else if (in_item.cmd == knn_pkg::CMD_LOAD
                         || in_item.cmd == knn_pkg::CMD_QUERY) begin
              pos <= in_item.last_feature ? 7'd0 : cnt;
              if (in_item.last_feature && in_item.cmd == knn_pkg::CMD_LOAD) begin
                if (cnt == len_eff && stored < CntW'(knn_pkg::MaxTraining))
                  stored <= stored + 1'b1;
              end else if (in_item.last_feature) begin
                if (cnt != len_eff) begin
                  out_valid <= 1'b1;
                  out_item  <= '{4'd0, knn_pkg::ST_MISMATCH};
                end else if (stored == '0) begin
                  out_valid <= 1'b1;
                  out_item  <= '{4'd0, knn_pkg::ST_EMPTY};
                end else begin
                  state  <= S_WALK;
                  w_slot <= '0;
                  w_feat <= '0;
                end
              end
            end else begin
            end
          end
        end
        S_WALK: begin
          p1_end <= w_last_feat;
          if (w_last_feat) begin
            w_feat <= '0;
            if (w_last_slot) begin
              state     <= S_DRAIN;
              drain_cnt <= '0;
            end else w_slot <= w_slot + 1'b1;
          end else w_feat <= w_feat + 1'b1;
        end
        S_DRAIN: begin
          drain_cnt <= drain_cnt + 1'b1;
          if (drain_cnt == 6'(knn_pkg::MaxK + 1)) begin
            state <= S_VOTE;
            vi    <= '0;
            votes <= '0;
          end
        end
        S_VOTE: begin
          if (vi < k_eff) votes[held[vi[knn_pkg::KW-1:0]].label]
                            <= votes[held[vi[knn_pkg::KW-1:0]].label] + 5'd1;
          if (vi == 5'(knn_pkg::MaxK - 1)) begin
            state <= S_SCAN;
            vi    <= '0;
            maxc  <= '0;
            best  <= '0;
          end else vi <= vi + 5'd1;
        end
        S_SCAN: begin
          if (votes[vi[3:0]] > maxc) begin
            maxc <= votes[vi[3:0]];
            best <= vi[3:0];
          end
          vi <= vi + 5'd1;
          if (vi == 5'(knn_pkg::NumClasses)) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
            out_item  <= '{best, knn_pkg::ST_OK};
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // label, accumulator and candidate index follow the pipeline
  logic [3:0] l1;
  always_ff @(posedge clk) begin
    l1       <= rd_l;
    vote_lbl <= l1;
    if (!p3_vld || p3_end) acc <= '0;
    else acc <= acc + knn_pkg::DistW'(sq);
    if (accept) cand_idx <= '0;
    else if (chain[0].vld) cand_idx <= cand_idx + 1'b1;
  end

  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (stored != '0)) else $error("walk on empty store");

endmodule
